FILE: rtl/deadline_timer_min_heap_defines.svh
// ----------------------------------------------------------------------------
// deadline timer assertion macros
// shared property wrappers for the timer heap rtl
// ----------------------------------------------------------------------------
`ifndef DEADLINE_TIMER_MIN_HEAP_DEFINES_SVH
`define DEADLINE_TIMER_MIN_HEAP_DEFINES_SVH

// same-cycle implication
`define DTMH_ASSERT_HOLD(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define DTMH_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/dtmh_pkg.sv
// ----------------------------------------------------------------------------
// deadline timer package
// shared types, codes and constants of the timer heap
// ----------------------------------------------------------------------------
`default_nettype none

package dtmh_pkg;

	localparam int NUM_CONN     = 64;
	localparam int CONN_W       = 6;
	localparam int CAPACITY_DEF = 64;
	localparam logic [15:0] IDLE_WAIT_RST = 16'd5;

	typedef enum logic [1:0] {
		OP_ARM    = 2'd0,
		OP_CANCEL = 2'd1,
		OP_UPDATE = 2'd2,
		OP_TICK   = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK         = 2'd0,
		ST_FULL       = 2'd1,
		ST_NOT_ARMED  = 2'd2
	} status_t;

	typedef struct packed {
		op_t               op;
		logic [CONN_W-1:0] conn;
		logic [19:0]       timeout;
		logic [31:0]       now;
	} cmd_t;

	typedef struct packed {
		status_t           status;
		logic              expired_valid;
		logic [CONN_W-1:0] expired_conn;
		logic [31:0]       next_wait;
		logic              last;
	} result_t;

	typedef struct packed {
		logic [CONN_W-1:0] conn;
		logic [31:0]       key;
	} slot_t;

	function automatic result_t mk_result(input status_t st, input logic v,
			input logic [CONN_W-1:0] c, input logic [31:0] w, input logic l);
		result_t r;
		r.status        = st;
		r.expired_valid = v;
		r.expired_conn  = c;
		r.next_wait     = w;
		r.last          = l;
		return r;
	endfunction

	function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [19:0] b);
		logic [32:0] s;
		s = {1'b0, a} + {13'b0, b};
		return s[32] ? 32'hFFFF_FFFF : s[31:0];
	endfunction

endpackage

`default_nettype wire

FILE: rtl/dtmh_heap_mem.sv
// ----------------------------------------------------------------------------
// heap slot memory
// one write and one registered read port, holds connection and deadline
// ----------------------------------------------------------------------------
`default_nettype none

module dtmh_heap_mem
	import dtmh_pkg::*;
#(
	parameter int DEPTH = CAPACITY_DEF,
	parameter int AW    = $clog2(DEPTH)
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire slot_t         wdata,
	input  wire logic          re,
	input  wire logic [AW-1:0] raddr,
	output slot_t              rdata
);

	slot_t mem [DEPTH];
	slot_t rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

FILE: rtl/dtmh_pos_map.sv
// ----------------------------------------------------------------------------
// position map
// heap position per connection, valid bits make unarmed entries read zero
// ----------------------------------------------------------------------------
`default_nettype none

module dtmh_pos_map
	import dtmh_pkg::*;
#(
	parameter int PW = 7
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              we,
	input  wire logic [CONN_W-1:0] waddr,
	input  wire logic [PW-1:0]     wdata,
	input  wire logic              clr,
	input  wire logic [CONN_W-1:0] caddr,
	input  wire logic [CONN_W-1:0] raddr,
	output logic [PW-1:0]          rdata
);

	logic [PW-1:0] mem [NUM_CONN];
	logic [NUM_CONN-1:0] valid_q;
	logic [PW-1:0] rdata_q;
	logic rvalid_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= '0;
			rvalid_q <= 1'b0;
		end else begin
			rvalid_q <= valid_q[raddr];
			if (we) begin
				valid_q[waddr] <= 1'b1;
			end
			if (clr) begin
				valid_q[caddr] <= 1'b0;
			end
		end
	end

	assign rdata = rvalid_q ? rdata_q : '0;

endmodule

`default_nettype wire

FILE: rtl/deadline_timer_min_heap.sv
// ----------------------------------------------------------------------------
// deadline timer min-heap
// connections ordered by absolute deadline in a binary heap held in memory
// ----------------------------------------------------------------------------
//  channel  | signals                      | handshake
//  command  | start, busy, cmd             | taken when start and not busy
//  result   | result_valid, result         | one-cycle strobe, no back-pressure
//  config   | cfg_we, cfg_wdata            | written when cfg_we is high
//
//  not-armed, full and tail-slot cancel items are answered without a heap pass;
//  arm moves up with a read and compare per level, a down pass reads the
//  children and compares per level; all accesses share the one heap memory,
//  and a new command is taken only once the last item has finished.
//  a tick pops each expired root and runs one down and up pass per expiry.
//  reset empties the heap at once through the position valid bits.
//  results cannot be stalled; busy falls as the last one is presented.
// ----------------------------------------------------------------------------
`default_nettype none

`include "deadline_timer_min_heap_defines.svh"

module deadline_timer_min_heap
	import dtmh_pkg::*;
#(
	parameter int CAPACITY = CAPACITY_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire cmd_t        cmd,
	output logic             result_valid,
	output result_t          result,
	input  wire logic        cfg_we,
	input  wire logic [15:0] cfg_wdata
);

	localparam int PW = $clog2(CAPACITY + 1);
	localparam int AW = $clog2(CAPACITY);

	typedef enum logic [3:0] {
		S_IDLE, S_PRD, S_CN_MV, S_UP_RD, S_UP_CMP, S_DN_RD, S_DN_RD2,
		S_DN_CMP, S_TK_RD, S_TK_CHK, S_TK_MV
	} state_t;

	state_t state_q;
	cmd_t cmd_q;
	logic [PW-1:0] p_q, fill_q;
	logic [PW:0] j_q;
	slot_t elem_q, child_q;
	logic second_q, tick_q, pend_q;
	logic [CONN_W-1:0] pend_conn_q;
	result_t res_q;
	logic res_valid_q;
	logic [15:0] idle_wait_q;

	slot_t hrd;
	logic [PW-1:0] prd;
	logic h_we, h_re;
	logic [AW-1:0] h_waddr, h_raddr;
	slot_t h_wdata;
	logic p_clr;
	logic [CONN_W-1:0] p_caddr;

	logic [PW:0] jn, fill_x, pick_j;
	logic right_sel, dn_swap, up_swap, pop;
	slot_t pick;
	logic [31:0] dl;

	function automatic logic [AW-1:0] slot_addr(input logic [PW-1:0] p);
		logic [PW-1:0] t;
		t = p - PW'(1);
		return t[AW-1:0];
	endfunction

	assign jn        = {p_q, 1'b0};
	assign fill_x    = {1'b0, fill_q};
	assign right_sel = (j_q < fill_x) && (child_q.key > hrd.key);
	assign pick      = right_sel ? hrd : child_q;
	assign pick_j    = right_sel ? j_q + (PW+1)'(1) : j_q;
	assign dn_swap   = elem_q.key > pick.key;
	assign up_swap   = hrd.key > elem_q.key;
	assign pop       = hrd.key <= cmd_q.now;
	assign dl        = sat_add(cmd_q.now, cmd_q.timeout);

	always_comb begin
		h_we    = 1'b0;
		h_waddr = slot_addr(p_q);
		h_wdata = elem_q;
		h_re    = 1'b0;
		h_raddr = '0;
		p_clr   = 1'b0;
		p_caddr = cmd_q.conn;
		unique case (state_q)
			S_PRD: begin
				if (cmd_q.op == OP_CANCEL && prd != '0) begin
					p_clr = 1'b1;
					if (prd < fill_q) begin
						h_re    = 1'b1;
						h_raddr = slot_addr(fill_q);
					end
				end
			end
			S_UP_RD: begin
				if (p_q > PW'(1)) begin
					h_re    = 1'b1;
					h_raddr = slot_addr(p_q >> 1);
				end else begin
					h_we = 1'b1;
				end
			end
			S_UP_CMP: begin
				h_we    = 1'b1;
				h_wdata = up_swap ? hrd : elem_q;
			end
			S_DN_RD: begin
				if (jn <= fill_x) begin
					h_re    = 1'b1;
					h_raddr = slot_addr(jn[PW-1:0]);
				end else begin
					h_we = 1'b1;
				end
			end
			S_DN_RD2: begin
				if (j_q < fill_x) begin
					h_re    = 1'b1;
					h_raddr = slot_addr(j_q[PW-1:0] + PW'(1));
				end
			end
			S_DN_CMP: begin
				h_we    = 1'b1;
				h_wdata = dn_swap ? pick : elem_q;
			end
			S_TK_RD: begin
				if (fill_q != '0) begin
					h_re    = 1'b1;
					h_raddr = slot_addr(PW'(1));
				end
			end
			S_TK_CHK: begin
				if (pop) begin
					p_clr   = 1'b1;
					p_caddr = hrd.conn;
					if (fill_q > PW'(1)) begin
						h_re    = 1'b1;
						h_raddr = slot_addr(fill_q);
					end
				end
			end
			default: begin
			end
		endcase
	end

	dtmh_heap_mem #(.DEPTH(CAPACITY), .AW(AW)) u_heap (
		.clk   (clk),
		.we    (h_we),
		.waddr (h_waddr),
		.wdata (h_wdata),
		.re    (h_re),
		.raddr (h_raddr),
		.rdata (hrd)
	);

	dtmh_pos_map #(.PW(PW)) u_pos (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (h_we),
		.waddr  (h_wdata.conn),
		.wdata  (p_q),
		.clr    (p_clr),
		.caddr  (p_caddr),
		.raddr  (cmd.conn),
		.rdata  (prd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			fill_q      <= '0;
			second_q    <= 1'b0;
			tick_q      <= 1'b0;
			pend_q      <= 1'b0;
			res_valid_q <= 1'b0;
			idle_wait_q <= IDLE_WAIT_RST;
		end else begin
			res_valid_q <= 1'b0;
			if (cfg_we) begin
				idle_wait_q <= cfg_wdata;
			end
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						cmd_q  <= cmd;
						pend_q <= 1'b0;
						if (cmd.op == OP_TICK) begin
							state_q <= S_TK_RD;
						end else if (32'(cmd.conn) >= CAPACITY) begin
							res_q       <= mk_result(ST_NOT_ARMED, 1'b0, '0, '0, 1'b1);
							res_valid_q <= 1'b1;
						end else begin
							state_q <= S_PRD;
						end
					end
				end
				S_PRD: begin
					priority if (cmd_q.op == OP_ARM && prd == '0) begin
						if (fill_q >= PW'(CAPACITY)) begin
							res_q       <= mk_result(ST_FULL, 1'b0, '0, '0, 1'b1);
							res_valid_q <= 1'b1;
							state_q     <= S_IDLE;
						end else begin
							fill_q   <= fill_q + PW'(1);
							p_q      <= fill_q + PW'(1);
							elem_q   <= '{conn: cmd_q.conn, key: dl};
							second_q <= 1'b0;
							tick_q   <= 1'b0;
							state_q  <= S_UP_RD;
						end
					end else if (prd == '0) begin
						res_q       <= mk_result(ST_NOT_ARMED, 1'b0, '0, '0, 1'b1);
						res_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end else if (cmd_q.op == OP_CANCEL) begin
						fill_q <= fill_q - PW'(1);
						p_q    <= prd;
						if (prd < fill_q) begin
							state_q <= S_CN_MV;
						end else begin
							res_q       <= mk_result(ST_OK, 1'b0, '0, '0, 1'b1);
							res_valid_q <= 1'b1;
							state_q     <= S_IDLE;
						end
					end else begin
						elem_q   <= '{conn: cmd_q.conn, key: dl};
						p_q      <= prd;
						second_q <= 1'b1;
						tick_q   <= 1'b0;
						state_q  <= S_UP_RD;
					end
				end
				S_CN_MV: begin
					elem_q   <= hrd;
					second_q <= 1'b1;
					tick_q   <= 1'b0;
					state_q  <= S_DN_RD;
				end
				S_UP_RD, S_UP_CMP, S_DN_RD, S_DN_CMP: begin
					priority if (state_q == S_UP_RD && p_q > PW'(1)) begin
						state_q <= S_UP_CMP;
					end else if (state_q == S_UP_CMP && up_swap) begin
						p_q     <= p_q >> 1;
						state_q <= S_UP_RD;
					end else if (state_q == S_DN_RD && jn <= fill_x) begin
						j_q     <= jn;
						state_q <= S_DN_RD2;
					end else if (state_q == S_DN_CMP && dn_swap) begin
						p_q     <= pick_j[PW-1:0];
						state_q <= S_DN_RD;
					end else if (second_q) begin
						second_q <= 1'b0;
						state_q  <= (state_q == S_UP_RD || state_q == S_UP_CMP)
							? S_DN_RD : S_UP_RD;
					end else if (tick_q) begin
						state_q <= S_TK_RD;
					end else begin
						res_q       <= mk_result(ST_OK, 1'b0, '0, '0, 1'b1);
						res_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				S_DN_RD2: begin
					child_q <= hrd;
					state_q <= S_DN_CMP;
				end
				S_TK_RD: begin
					if (fill_q == '0) begin
						res_q       <= mk_result(ST_OK, pend_q, pend_q ? pend_conn_q : '0,
							32'(idle_wait_q), 1'b1);
						res_valid_q <= 1'b1;
						pend_q      <= 1'b0;
						state_q     <= S_IDLE;
					end else begin
						state_q <= S_TK_CHK;
					end
				end
				S_TK_CHK: begin
					if (pop) begin
						if (pend_q) begin
							res_q       <= mk_result(ST_OK, 1'b1, pend_conn_q, '0, 1'b0);
							res_valid_q <= 1'b1;
						end
						pend_q      <= 1'b1;
						pend_conn_q <= hrd.conn;
						fill_q      <= fill_q - PW'(1);
						state_q     <= (fill_q > PW'(1)) ? S_TK_MV : S_TK_RD;
					end else begin
						res_q       <= mk_result(ST_OK, pend_q, pend_q ? pend_conn_q : '0,
							hrd.key - cmd_q.now, 1'b1);
						res_valid_q <= 1'b1;
						pend_q      <= 1'b0;
						state_q     <= S_IDLE;
					end
				end
				S_TK_MV: begin
					elem_q   <= hrd;
					p_q      <= PW'(1);
					second_q <= 1'b1;
					tick_q   <= 1'b1;
					state_q  <= S_DN_RD;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy         = state_q != S_IDLE;
	assign result_valid = res_valid_q;
	assign result       = res_q;

	`DTMH_ASSERT_HOLD(a_fill_bound, 1'b1, fill_q <= PW'(CAPACITY), "fill count above capacity")
	`DTMH_ASSERT_HOLD(a_write_in_heap, h_we, p_q != '0 && p_q <= fill_q, "heap write outside fill")
	`DTMH_ASSERT_HOLD(a_idle_no_pend, state_q == S_IDLE, !pend_q, "pending pop left when idle")
	`DTMH_ASSERT_NEXT(a_start_busy, start && !busy && cmd.op == OP_TICK, busy, "tick not taken")

endmodule

`default_nettype wire
